// File: src/host_command_frame_builder_assert.svh
// Assertion macros used by the frame builder RTL.
`ifndef HOST_COMMAND_FRAME_BUILDER_ASSERT_SVH
`define HOST_COMMAND_FRAME_BUILDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define HCFB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("frame builder assertion failed");

`define HCFB_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("frame builder forbidden condition seen");

`else

`define HCFB_ASSERT(lbl, prop)

`define HCFB_ASSERT_NEVER(lbl, cond)

`endif

`endif

// File: src/hcfb_pkg.sv
// Types and constants shared by the frame builder modules.
package hcfb_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;
  localparam int RegIdxW = 3;

  localparam logic [7:0] CountMax = 8'd254;

  typedef enum logic [RegIdxW-1:0] {
    REG_PRE_FIRST  = 3'd0,
    REG_PRE_SECOND = 3'd1,
    REG_START      = 3'd2,
    REG_IDENT      = 3'd3,
    REG_POST       = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_HEAD,
    PH_PRE0,
    PH_PRE1,
    PH_START,
    PH_LEN,
    PH_LCS,
    PH_ID,
    PH_DATA,
    PH_DCS,
    PH_POST
  } phase_e;

  typedef struct packed {
    logic [7:0] pre_first;
    logic [7:0] pre_second;
    logic [7:0] start_code;
    logic [7:0] ident;
    logic [7:0] post;
  } cfg_t;

  // One classified payload transaction.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] count;
    logic [7:0] data;
    logic [7:0] cksum;
  } entry_t;

  typedef struct packed {
    logic       in_frame;
    logic       left_zero;
  } fe_status_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bk_status_t;

endpackage

// File: src/host_command_frame_builder.sv
// Command frame builder: wraps payload bytes into checksummed information frames.
//
// Input channel (in_valid_i/in_ready_o): one payload byte per transaction; the
// first transaction of a frame also carries payload_count_i (0 read as 1,
// 255 read as 254). Output channel (out_valid_o/out_ready_i): one frame byte
// per transaction, frame_end_o high on the postamble.
// Frame: 3 preamble bytes, length, length checksum, identifier, payload,
// data checksum, postamble. Preamble, identifier and postamble come from the
// write port (cfg_we_i, cfg_idx_i, cfg_data_i); write only while idle.
// The first frame byte of an accepted transaction passes the queue, then the
// output register, the single byte lane: one byte per cycle while the queue
// holds an entry and out_ready_i does not stall it. A frame's first byte adds
// preamble, length, its checksum, identifier; the last, data checksum, postamble.
// A 4-entry queue sits between the front end and the sequencer, so input is
// taken while output bytes are pending; in_ready_o drops when it fills.
// Output stall holds the output register; the queue absorbs up to 4 bytes.
// Reset clears the frame state, queue and output valid and loads the
// register defaults (start code 0xFF, identifier 0xD4, others 0x00).
module host_command_frame_builder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hcfb_pkg::RegIdxW-1:0]    cfg_idx_i,
  input  logic [7:0]                      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      payload_byte_i,
  input  logic [7:0]                      payload_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      frame_byte_o,
  output logic                            frame_end_o
);
  import hcfb_pkg::*;

`include "host_command_frame_builder_assert.svh"

  cfg_t       cfg_q, cfg_d;
  entry_t     push_entry, head;
  logic       q_push, q_full, q_valid;
  fe_status_t fe_st;
  bk_status_t bk_st;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PRE_FIRST:  cfg_d.pre_first  = cfg_data_i;
        REG_PRE_SECOND: cfg_d.pre_second = cfg_data_i;
        REG_START:      cfg_d.start_code = cfg_data_i;
        REG_IDENT:      cfg_d.ident      = cfg_data_i;
        REG_POST:       cfg_d.post       = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_first  <= 8'h00;
      cfg_q.pre_second <= 8'h00;
      cfg_q.start_code <= 8'hFF;
      cfg_q.ident      <= 8'hD4;
      cfg_q.post       <= 8'h00;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hcfb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .payload_byte_i (payload_byte_i),
    .payload_count_i(payload_count_i),
    .ident_i        (cfg_q.ident),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (push_entry),
    .st_o           (fe_st)
  );

  hcfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .pop_i       (bk_st.pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  hcfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .st_o        (bk_st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_byte_o(frame_byte_o),
    .frame_end_o (frame_end_o)
  );

  `HCFB_ASSERT_NEVER(a_open_frame_has_bytes, fe_st.in_frame && fe_st.left_zero)
  `HCFB_ASSERT(a_pop_needs_entry, bk_st.pop |-> q_valid)
  `HCFB_ASSERT(a_busy_holds_head, bk_st.busy |-> q_valid)

endmodule

// File: src/hcfb_front.sv
// Front end: accepts payload bytes, tracks frame position and checksum.
module hcfb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          payload_byte_i,
  input  logic [7:0]          payload_count_i,
  input  logic [7:0]          ident_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output hcfb_pkg::entry_t    q_entry_o,
  output hcfb_pkg::fe_status_t st_o
);
  import hcfb_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] count;
  logic [7:0] left_new;
  logic [7:0] sum;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    count = payload_count_i;
    if (count == 8'd0) begin
      count = 8'd1;
    end else if (count > CountMax) begin
      count = CountMax;
    end
    if (!in_frame_q) begin
      left_new = count - 8'd1;
      sum      = ident_i + payload_byte_i;
    end else begin
      left_new = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : 8'd0;
      sum      = running_sum_q + payload_byte_i;
    end

    q_entry_o.first = !in_frame_q;
    q_entry_o.last  = (left_new == 8'd0);
    q_entry_o.count = count;
    q_entry_o.data  = payload_byte_i;
    q_entry_o.cksum = 8'd0 - sum;

    in_frame_d    = in_frame_q;
    bytes_left_d  = bytes_left_q;
    running_sum_d = running_sum_q;
    if (accept) begin
      if (left_new == 8'd0) begin
        in_frame_d    = 1'b0;
        bytes_left_d  = 8'd0;
        running_sum_d = 8'd0;
      end else begin
        in_frame_d    = 1'b1;
        bytes_left_d  = left_new;
        running_sum_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      bytes_left_q  <= 8'd0;
      running_sum_q <= 8'd0;
    end else begin
      in_frame_q    <= in_frame_d;
      bytes_left_q  <= bytes_left_d;
      running_sum_q <= running_sum_d;
    end
  end

  assign st_o.in_frame  = in_frame_q;
  assign st_o.left_zero = (bytes_left_q == 8'd0);

endmodule

// File: src/hcfb_queue.sv
// Small FIFO between front end and frame sequencer.
module hcfb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hcfb_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output hcfb_pkg::entry_t head_o
);
  import hcfb_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: src/hcfb_back.sv
// Frame sequencer: expands queued transactions into frame bytes.
module hcfb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hcfb_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  input  hcfb_pkg::entry_t     q_head_i,
  output hcfb_pkg::bk_status_t st_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           frame_byte_o,
  output logic                 frame_end_o
);
  import hcfb_pkg::*;

  phase_e     phase_q, phase_d;
  phase_e     slot, nxt;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d, slot_byte;
  logic       end_q, end_d, slot_end;
  logic       load, fire, done;

  always_comb begin
    load = !out_valid_q || out_ready_i;
    fire = q_valid_i && load;

    if (phase_q == PH_HEAD) begin
      slot = q_head_i.first ? PH_PRE0 : PH_DATA;
    end else begin
      slot = phase_q;
    end

    slot_byte = 8'd0;
    slot_end  = 1'b0;
    nxt       = PH_HEAD;
    done      = 1'b0;
    case (slot)
      PH_PRE0: begin
        slot_byte = cfg_i.pre_first;
        nxt       = PH_PRE1;
      end
      PH_PRE1: begin
        slot_byte = cfg_i.pre_second;
        nxt       = PH_START;
      end
      PH_START: begin
        slot_byte = cfg_i.start_code;
        nxt       = PH_LEN;
      end
      PH_LEN: begin
        slot_byte = q_head_i.count + 8'd1;
        nxt       = PH_LCS;
      end
      PH_LCS: begin
        slot_byte = ~q_head_i.count;
        nxt       = PH_ID;
      end
      PH_ID: begin
        slot_byte = cfg_i.ident;
        nxt       = PH_DATA;
      end
      PH_DATA: begin
        slot_byte = q_head_i.data;
        if (q_head_i.last) begin
          nxt = PH_DCS;
        end else begin
          done = 1'b1;
        end
      end
      PH_DCS: begin
        slot_byte = q_head_i.cksum;
        nxt       = PH_POST;
      end
      PH_POST: begin
        slot_byte = cfg_i.post;
        slot_end  = 1'b1;
        done      = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase

    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    end_d       = end_q;
    st_o.pop    = 1'b0;
    if (fire) begin
      out_valid_d = 1'b1;
      byte_d      = slot_byte;
      end_d       = slot_end;
      if (done) begin
        phase_d  = PH_HEAD;
        st_o.pop = 1'b1;
      end else begin
        phase_d = nxt;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    st_o.busy = (phase_q != PH_HEAD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    end_q  <= end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign frame_end_o  = end_q;

endmodule
